// ===== rtl/camera_exposure_gain_regulator_defines.svh =====
// Assertion macros used by the regulator RTL.
`ifndef CAMERA_EXPOSURE_GAIN_REGULATOR_DEFINES_SVH
`define CAMERA_EXPOSURE_GAIN_REGULATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CEG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ceg assertion failed");

// Next-cycle implication, checked outside reset.
`define CEG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ceg assertion failed");

`endif

// ===== rtl/ceg_pkg.sv =====
`timescale 1ns / 1ps

package ceg_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 10;
   localparam int EXPOSURE_STEP        = 10;
   localparam int GAIN_STEP            = 5;

   localparam int BRIGHT_W   = 8;
   localparam int EXPOSURE_W = 12;
   localparam int GAIN_W     = 8;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   localparam logic [BRIGHT_W-1:0]   WINDOW_FILL    = 8'd200;
   localparam logic [EXPOSURE_W-1:0] EXPOSURE_RESET = 12'd50;
   localparam logic [GAIN_W-1:0]     GAIN_RESET     = 8'd70;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_BRIGHTNESS  = 3'd0,
      CSR_MAX_BRIGHTNESS  = 3'd1,
      CSR_HYSTERESIS      = 3'd2,
      CSR_EXPOSURE_MIN    = 3'd3,
      CSR_EXPOSURE_MAX    = 3'd4,
      CSR_GAIN_MIN        = 3'd5,
      CSR_GAIN_MAX        = 3'd6,
      CSR_UPDATE_INTERVAL = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [BRIGHT_W-1:0]   min_brightness;
      logic [BRIGHT_W-1:0]   max_brightness;
      logic [BRIGHT_W-1:0]   hysteresis;
      logic [EXPOSURE_W-1:0] exposure_min;
      logic [EXPOSURE_W-1:0] exposure_max;
      logic [GAIN_W-1:0]     gain_min;
      logic [GAIN_W-1:0]     gain_max;
      logic [INTERVAL_W-1:0] update_interval;
   } cfg_type;

   typedef struct packed {
      logic [BRIGHT_W-1:0]   average_brightness;
      logic                  gave_up_to_auto;
      logic                  auto_exposure;
      logic [GAIN_W-1:0]     gain;
      logic [EXPOSURE_W-1:0] exposure;
   } result_type;

endpackage

// ===== rtl/ceg_window.sv =====
`timescale 1ns / 1ps

module ceg_window
   import ceg_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [BRIGHT_W-1:0] brightness,
   output logic [BRIGHT_W-1:0] average
);

   localparam int HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_W  = $clog2(255 * WINDOW_DEPTH + 1);
   // Reciprocal multiply: exact truncated quotient for every SUM_W-bit sum.
   localparam int DIV_L  = $clog2(WINDOW_DEPTH);
   localparam int DIV_S  = SUM_W + DIV_L;
   localparam int DIV_M  = ((1 << DIV_S) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
   localparam int PROD_W = 2 * SUM_W + 1;
   localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(WINDOW_DEPTH - 1);

   logic [BRIGHT_W-1:0] win_ff [WINDOW_DEPTH];
   logic [HEAD_W-1:0]   head_ff, head_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [BRIGHT_W-1:0] avg_ff, avg_in;
   logic [PROD_W-1:0]   prod;

   always_comb begin
      head_in = (head_ff == HEAD_LAST) ? '0 : head_ff + 1'b1;
      sum_in  = sum_ff - SUM_W'(win_ff[head_ff]) + SUM_W'(brightness);
      prod    = PROD_W'(sum_in) * PROD_W'(DIV_M);
      avg_in  = BRIGHT_W'(prod >> DIV_S);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win_ff[i] <= WINDOW_FILL;
         end
         head_ff <= '0;
         sum_ff  <= SUM_W'(200 * WINDOW_DEPTH);
      end else if (push) begin
         win_ff[head_ff] <= brightness;
         head_ff         <= head_in;
         sum_ff          <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         avg_ff <= avg_in;
      end
   end

   assign average = avg_ff;

endmodule

// ===== rtl/ceg_regulator.sv =====
`timescale 1ns / 1ps
`include "camera_exposure_gain_regulator_defines.svh"

module ceg_regulator
   import ceg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                step,
   input  logic [TIME_W-1:0]   frame_time,
   input  logic [BRIGHT_W-1:0] average,
   output result_type          result
);

   logic [EXPOSURE_W-1:0] exposure_ff, exposure_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic                  auto_ff, auto_in;
   logic                  latched_ff, latched_in;
   logic                  dark_ff, dark_in;
   logic [TIME_W-1:0]     last_ff, last_in;
   logic [BRIGHT_W-1:0]   avg_ff;

   logic [TIME_W-1:0]     elapsed;
   logic                  due;
   logic [BRIGHT_W:0]     dark_thr, bright_thr;
   logic                  too_dark, too_bright;
   logic signed [14:0]    exp_up;
   logic signed [13:0]    exp_dn;
   logic [GAIN_W+1:0]     gain_up;
   logic signed [GAIN_W+1:0] gain_dn;
   logic [EXPOSURE_W-1:0] exp_up_sat, exp_dn_sat;
   logic [GAIN_W-1:0]     gain_up_sat, gain_dn_sat;

   always_comb begin
      // Backward timestamps read as negative and never trigger.
      elapsed = frame_time - last_ff;
      due     = !elapsed[TIME_W-1] && (elapsed > TIME_W'(cfg.update_interval));

      dark_thr   = {1'b0, cfg.min_brightness}
                 + (dark_ff ? {1'b0, cfg.hysteresis} : '0);
      bright_thr = {1'b0, cfg.max_brightness}
                 + (dark_ff ? '0 : {1'b0, cfg.hysteresis});
      too_dark   = {1'b0, average} < dark_thr;
      too_bright = {1'b0, average} > bright_thr;

      exp_up = $signed({3'b000, exposure_ff}) + $signed(15'(EXPOSURE_STEP))
             + $signed({7'b0, cfg.min_brightness}) - $signed({7'b0, average});
      if (exp_up > $signed({3'b000, cfg.exposure_max})) begin
         exp_up_sat = cfg.exposure_max;
      end else if (exp_up < 0) begin
         exp_up_sat = '0;
      end else begin
         exp_up_sat = exp_up[EXPOSURE_W-1:0];
      end

      exp_dn = $signed({2'b00, exposure_ff}) - $signed(14'(EXPOSURE_STEP));
      if (exp_dn < $signed({2'b00, cfg.exposure_min})) begin
         exp_dn_sat = cfg.exposure_min;
      end else begin
         exp_dn_sat = exp_dn[EXPOSURE_W-1:0];
      end

      gain_up = {2'b00, gain_ff} + (GAIN_W+2)'(GAIN_STEP);
      if (gain_up > {2'b00, cfg.gain_max}) begin
         gain_up_sat = cfg.gain_max;
      end else begin
         gain_up_sat = gain_up[GAIN_W-1:0];
      end

      gain_dn = $signed({2'b00, gain_ff}) - $signed((GAIN_W+2)'(GAIN_STEP));
      if (gain_dn < $signed({2'b00, cfg.gain_min})) begin
         gain_dn_sat = cfg.gain_min;
      end else begin
         gain_dn_sat = gain_dn[GAIN_W-1:0];
      end
   end

   always_comb begin
      exposure_in = exposure_ff;
      gain_in     = gain_ff;
      auto_in     = auto_ff;
      latched_in  = latched_ff;
      dark_in     = dark_ff;
      last_in     = last_ff;
      if (due) begin
         last_in = frame_time;
         if (auto_ff) begin
            // Leave auto only when not latched, exposure is above exposure_max and the scene is bright.
            if (!latched_ff && (exposure_ff > cfg.exposure_max)
                  && (average > cfg.max_brightness)) begin
               auto_in     = 1'b0;
               exposure_in = cfg.exposure_max;
               gain_in     = cfg.gain_min;
            end
         end else if (too_dark) begin
            dark_in = 1'b1;
            if (exposure_ff < cfg.exposure_max) begin
               exposure_in = exp_up_sat;
            end else if (gain_ff < cfg.gain_max) begin
               gain_in = gain_up_sat;
            end else begin
               auto_in    = 1'b1;
               latched_in = 1'b1;
            end
         end else if (too_bright) begin
            dark_in = 1'b0;
            if (gain_ff > cfg.gain_min) begin
               gain_in = gain_dn_sat;
            end else if (exposure_ff > cfg.exposure_min) begin
               exposure_in = exp_dn_sat;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exposure_ff <= EXPOSURE_RESET;
         gain_ff     <= GAIN_RESET;
         auto_ff     <= 1'b1;
         latched_ff  <= 1'b0;
         dark_ff     <= 1'b0;
         last_ff     <= '0;
      end else if (step) begin
         exposure_ff <= exposure_in;
         gain_ff     <= gain_in;
         auto_ff     <= auto_in;
         latched_ff  <= latched_in;
         dark_ff     <= dark_in;
         last_ff     <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         avg_ff <= average;
      end
   end

   assign result.exposure           = exposure_ff;
   assign result.gain               = gain_ff;
   assign result.auto_exposure      = auto_ff;
   assign result.gave_up_to_auto    = latched_ff;
   assign result.average_brightness = avg_ff;

   `CEG_ASSERT_SAME(a_latched_is_auto, clock, reset, latched_ff, auto_ff)
   `CEG_ASSERT_NEXT(a_latch_holds, clock, reset, latched_ff, latched_ff)
   `CEG_ASSERT_NEXT(a_hold_without_step, clock, reset, !step, $stable(exposure_ff) && $stable(gain_ff) && $stable(auto_ff))

endmodule

// ===== rtl/camera_exposure_gain_regulator.sv =====
`timescale 1ns / 1ps

// Exposure and gain regulator for one camera. Each req beat is one frame
// (timestamp and measured field brightness); each one yields exactly one rsp
// beat with the current exposure, gain, mode flags and the window average.
// The block takes one frame per clock unless rsp backpressure holds it, and
// registers its result through the brightness window stage (running sum and
// constant divide), then the regulation stage (threshold compare and saturating
// step). rsp backpressure stalls both stages; a free stage still accepts.
// Configuration writes land at once and should only be made while idle.
module camera_exposure_gain_regulator
   import ceg_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,  // frame_time[31:0], brightness[39:32]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // exposure[11:0], gain[19:12], auto_exposure[20], gave_up_to_auto[21],
   // average_brightness[29:22], zero pad[31:30]
   output logic [31:0]           rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type             cfg_ff;
   logic                avg_valid_ff, avg_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]   time_ff;
   logic                out_ready, avg_ready;
   logic                push, step;
   logic [BRIGHT_W-1:0] average;
   result_type          result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_brightness  <= 8'd100;
         cfg_ff.max_brightness  <= 8'd140;
         cfg_ff.hysteresis      <= 8'd10;
         cfg_ff.exposure_min    <= 12'd1;
         cfg_ff.exposure_max    <= 12'd300;
         cfg_ff.gain_min        <= 8'd0;
         cfg_ff.gain_max        <= 8'd255;
         cfg_ff.update_interval <= 16'd300;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_BRIGHTNESS:  cfg_ff.min_brightness  <= csr_wdata[BRIGHT_W-1:0];
            CSR_MAX_BRIGHTNESS:  cfg_ff.max_brightness  <= csr_wdata[BRIGHT_W-1:0];
            CSR_HYSTERESIS:      cfg_ff.hysteresis      <= csr_wdata[BRIGHT_W-1:0];
            CSR_EXPOSURE_MIN:    cfg_ff.exposure_min    <= csr_wdata[EXPOSURE_W-1:0];
            CSR_EXPOSURE_MAX:    cfg_ff.exposure_max    <= csr_wdata[EXPOSURE_W-1:0];
            CSR_GAIN_MIN:        cfg_ff.gain_min        <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_MAX:        cfg_ff.gain_max        <= csr_wdata[GAIN_W-1:0];
            CSR_UPDATE_INTERVAL: cfg_ff.update_interval <= csr_wdata[INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   // A stage takes a beat when it is empty or its beat moves on.
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign avg_ready  = !avg_valid_ff || out_ready;
   assign req_tready = avg_ready;
   assign push       = req_tvalid && avg_ready;
   assign step       = avg_valid_ff && out_ready;

   always_comb begin
      avg_valid_in = push ? 1'b1 : (step ? 1'b0 : avg_valid_ff);
      rsp_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         avg_valid_ff <= avg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         time_ff <= req_tdata[TIME_W-1:0];
      end
   end

   ceg_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .brightness (req_tdata[TIME_W+BRIGHT_W-1:TIME_W]),
      .average    (average)
   );

   ceg_regulator u_regulator (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .step       (step),
      .frame_time (time_ff),
      .average    (average),
      .result     (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, result};

endmodule

// ===== sim/camera_exposure_gain_regulator_test.sv =====
`timescale 1ns / 1ps

module camera_exposure_gain_regulator_test;
   import ceg_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [BRIGHT_W-1:0] brightness;
      logic [TIME_W-1:0]   frame_time;
   } frame_beat_t;

   typedef struct packed {
      logic [WINDOW_DEPTH_DEFAULT-1:0][BRIGHT_W-1:0] window;
      logic [11:0]           sum;
      logic [3:0]            head;
      logic [TIME_W-1:0]     last_time;
      logic [EXPOSURE_W-1:0] exposure;
      logic [GAIN_W-1:0]     gain;
      logic                  auto_on;
      logic                  latched;
      logic                  too_dark;
   } regulator_state_t;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [39:0]           req_tdata = '0;  // frame_time[31:0], brightness[39:32]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // exposure[11:0], gain[19:12], auto_exposure[20], gave_up_to_auto[21],
   // average_brightness[29:22], zero pad[31:30]
   logic [31:0]           rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cfg_type          active_cfg;
   regulator_state_t regulator_model;
   regulator_state_t plan_model;
   frame_beat_t      pending_frames[$];
   result_type       expected_results[$];
   logic [31:0]      frame_clock = '0;
   int               error_count = 0;
   int               cycle_count = 0;
   int               gap_left = 0;
   int               burst_left = 0;
   logic [15:0]      ready_pattern = 16'hFFFF;
   int               pattern_pos = 0;

   camera_exposure_gain_regulator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic regulator_state_t power_on_state();
      regulator_state_t s;
      for (int i = 0; i < WINDOW_DEPTH_DEFAULT; i++) s.window[i] = WINDOW_FILL;
      s.sum       = 12'(int'(WINDOW_FILL) * WINDOW_DEPTH_DEFAULT);
      s.head      = '0;
      s.last_time = '0;
      s.exposure  = EXPOSURE_RESET;
      s.gain      = GAIN_RESET;
      s.auto_on   = 1'b1;
      s.latched   = 1'b0;
      s.too_dark  = 1'b0;
      return s;
   endfunction

   // One camera frame: push into the window, then regulate if the interval passed.
   function automatic result_type advance_frame(inout regulator_state_t s,
                                                input cfg_type c, input frame_beat_t f);
      int          avg;
      int          e;
      int          g;
      logic [31:0] elapsed;
      result_type  r;
      s.sum = s.sum - 12'(s.window[s.head]) + 12'(f.brightness);
      s.window[s.head] = f.brightness;
      s.head = (s.head == WINDOW_DEPTH_DEFAULT - 1) ? '0 : s.head + 1'b1;
      avg = int'(s.sum) / WINDOW_DEPTH_DEFAULT;
      elapsed = f.frame_time - s.last_time;
      if (!elapsed[31] && elapsed > c.update_interval) begin
         s.last_time = f.frame_time;
         if (s.auto_on) begin
            if (!s.latched && s.exposure > c.exposure_max && avg > int'(c.max_brightness)) begin
               s.auto_on  = 1'b0;
               s.exposure = c.exposure_max;
               s.gain     = c.gain_min;
            end
         end else if (avg < int'(c.min_brightness) + (s.too_dark ? int'(c.hysteresis) : 0)) begin
            s.too_dark = 1'b1;
            if (s.exposure < c.exposure_max) begin
               // shortfall goes negative once hysteresis widened the dark band
               e = int'(s.exposure) + EXPOSURE_STEP + int'(c.min_brightness) - avg;
               if (e > int'(c.exposure_max)) e = int'(c.exposure_max);
               if (e < 0) e = 0;
               s.exposure = 12'(e);
            end else if (s.gain < c.gain_max) begin
               g = int'(s.gain) + GAIN_STEP;
               if (g > int'(c.gain_max)) g = int'(c.gain_max);
               s.gain = 8'(g);
            end else begin
               s.auto_on = 1'b1;
               s.latched = 1'b1;
            end
         end else if (avg > int'(c.max_brightness) + (s.too_dark ? 0 : int'(c.hysteresis))) begin
            s.too_dark = 1'b0;
            if (s.gain > c.gain_min) begin
               g = int'(s.gain) - GAIN_STEP;
               if (g < int'(c.gain_min)) g = int'(c.gain_min);
               s.gain = 8'(g);
            end else if (s.exposure > c.exposure_min) begin
               e = int'(s.exposure) - EXPOSURE_STEP;
               if (e < int'(c.exposure_min)) e = int'(c.exposure_min);
               s.exposure = 12'(e);
            end
         end
      end
      r.exposure           = s.exposure;
      r.gain               = s.gain;
      r.auto_exposure      = s.auto_on;
      r.gave_up_to_auto    = s.latched;
      r.average_brightness = 8'(avg);
      return r;
   endfunction

   function void check_field(string name, int want, int got);
      if (want != got) begin
         error_count++;
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // Junk goes into the bits above the register width; the block must drop it.
   task automatic write_register(input csr_index_type idx, input logic [15:0] value);
      logic [15:0] junk;
      logic [15:0] mask;
      logic [15:0] wdata;
      junk = 16'($urandom);
      if (idx == CSR_EXPOSURE_MIN || idx == CSR_EXPOSURE_MAX) mask = 16'h0FFF;
      else if (idx == CSR_UPDATE_INTERVAL) mask = 16'hFFFF;
      else mask = 16'h00FF;
      wdata = (value & mask) | (junk & ~mask);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      case (idx)
         CSR_MIN_BRIGHTNESS:  active_cfg.min_brightness  = wdata[7:0];
         CSR_MAX_BRIGHTNESS:  active_cfg.max_brightness  = wdata[7:0];
         CSR_HYSTERESIS:      active_cfg.hysteresis      = wdata[7:0];
         CSR_EXPOSURE_MIN:    active_cfg.exposure_min    = wdata[11:0];
         CSR_EXPOSURE_MAX:    active_cfg.exposure_max    = wdata[11:0];
         CSR_GAIN_MIN:        active_cfg.gain_min        = wdata[7:0];
         CSR_GAIN_MAX:        active_cfg.gain_max        = wdata[7:0];
         CSR_UPDATE_INTERVAL: active_cfg.update_interval = wdata;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_frames.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic queue_frame(input logic [31:0] t, input logic [7:0] b);
      frame_beat_t f;
      f.frame_time = t;
      f.brightness = b;
      void'(advance_frame(plan_model, active_cfg, f));
      pending_frames.push_back(f);
   endtask

   task automatic pick_settings(input bit extremes);
      logic [15:0] v [8];
      if (extremes) begin
         for (int i = 0; i < 8; i++) v[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end else begin
         v[CSR_MIN_BRIGHTNESS]  = 16'($urandom_range(40, 150));
         v[CSR_MAX_BRIGHTNESS]  = 16'(v[CSR_MIN_BRIGHTNESS] + $urandom_range(0, 80));
         if (v[CSR_MAX_BRIGHTNESS] > 255) v[CSR_MAX_BRIGHTNESS] = 16'd255;
         v[CSR_HYSTERESIS]      = 16'($urandom_range(0, 30));
         v[CSR_EXPOSURE_MIN]    = 16'($urandom_range(0, 60));
         v[CSR_EXPOSURE_MAX]    = 16'($urandom_range(80, 4095));
         v[CSR_GAIN_MIN]        = 16'($urandom_range(0, 40));
         v[CSR_GAIN_MAX]        = 16'($urandom_range(120, 255));
         v[CSR_UPDATE_INTERVAL] = 16'($urandom_range(0, 500));
      end
      for (int i = 0; i < 8; i++) write_register(csr_index_type'(i), v[i]);
   endtask

   // Scene brightness drifts with noise; timestamps mostly advance, with odd jumps.
   task automatic plan_scene(input int count, input bit latch_ok);
      int               level;
      int               b;
      logic [31:0]      t;
      logic [31:0]      span;
      regulator_state_t trial;
      level = $urandom_range(0, 255);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 15) == 0) level = $urandom_range(0, 255);
         else level = level + int'($urandom_range(0, 16)) - 8;
         if (level < 0) level = 0;
         else if (level > 255) level = 255;
         case ($urandom_range(0, 29))
            0: b = 0;
            1: b = 255;
            2: b = $urandom_range(0, 255);
            default: b = level + int'($urandom_range(0, 40)) - 20;
         endcase
         if (b < 0) b = 0;
         else if (b > 255) b = 255;
         span = {16'd0, active_cfg.update_interval};
         case ($urandom_range(0, 39))
            0: t = plan_model.last_time + span;
            1: t = plan_model.last_time + span + 1;
            2: t = plan_model.last_time - $urandom_range(1, 1000);
            3: t = plan_model.last_time + 32'h7FFF_FFFF;
            4: t = plan_model.last_time + 32'h8000_0000;
            5: t = $urandom;
            default: begin
               frame_clock = frame_clock + $urandom_range(0, span / 3 + 30);
               t = frame_clock;
            end
         endcase
         // keep the permanent auto latch for the closing phase
         trial = plan_model;
         void'(advance_frame(trial, active_cfg, frame_beat_t'({b[7:0], t})));
         if (!latch_ok && trial.latched && !plan_model.latched) begin
            b = 255;
            trial = plan_model;
            void'(advance_frame(trial, active_cfg, frame_beat_t'({b[7:0], t})));
            if (trial.latched) t = plan_model.last_time;
         end
         queue_frame(t, b[7:0]);
         if ((frame_clock - plan_model.last_time) >= 32'h8000_0000)
            frame_clock = plan_model.last_time;
      end
   endtask

   always @(posedge clock) begin : feed_frames
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(advance_frame(regulator_model, active_cfg,
                                                     frame_beat_t'(req_tdata)));
         end
         if (!req_tvalid || req_tready) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_frames.size() > 0) begin
               req_tdata <= pending_frames.pop_front();
               next_valid = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            req_tvalid <= next_valid;
         end
      end
   end

   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = result_type'(rsp_tdata[29:0]);
            if (expected_results.size() == 0) begin
               error_count++;
               $error("result beat with no frame outstanding: %h", rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               check_field("exposure", want.exposure, seen.exposure);
               check_field("gain", want.gain, seen.gain);
               check_field("auto_exposure", want.auto_exposure, seen.auto_exposure);
               check_field("gave_up_to_auto", want.gave_up_to_auto, seen.gave_up_to_auto);
               check_field("average_brightness", want.average_brightness,
                           seen.average_brightness);
            end
         end
         rsp_tready <= ready_pattern[pattern_pos];
         if (pattern_pos == 15) begin
            pattern_pos = 0;
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
         end else begin
            pattern_pos++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      active_cfg.min_brightness  = 8'd100;
      active_cfg.max_brightness  = 8'd140;
      active_cfg.hysteresis      = 8'd10;
      active_cfg.exposure_min    = 12'd1;
      active_cfg.exposure_max    = 12'd300;
      active_cfg.gain_min        = 8'd0;
      active_cfg.gain_max        = 8'd255;
      active_cfg.update_interval = 16'd300;
      regulator_model = power_on_state();
      plan_model = power_on_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // auto mode at reset limits: interval edge, backwards and far-forward time
      queue_frame(32'd0, 8'd0);
      queue_frame(32'd300, 8'd255);
      queue_frame(32'd301, 8'd255);
      queue_frame(32'd301 + 32'h8000_0000, 8'd255);
      queue_frame(32'd301 + 32'h7FFF_FFFF, 8'd255);
      wait_idle();

      // bright scene above a tiny exposure_max drops to manual, then goes dark
      write_register(CSR_EXPOSURE_MAX, 16'd20);
      write_register(CSR_UPDATE_INTERVAL, 16'd0);
      @(negedge clock);
      for (int n = 0; n < 10; n++) queue_frame(plan_model.last_time + 1, (n == 0) ? 8'd255 : 8'd0);
      wait_idle();

      // thresholds past 255 and a large shortfall
      write_register(CSR_MIN_BRIGHTNESS, 16'd255);
      write_register(CSR_MAX_BRIGHTNESS, 16'd255);
      write_register(CSR_HYSTERESIS, 16'd255);
      write_register(CSR_EXPOSURE_MIN, 16'd0);
      write_register(CSR_EXPOSURE_MAX, 16'd4095);
      @(negedge clock);
      for (int n = 0; n < 3; n++) queue_frame(plan_model.last_time + 1, 8'd128);
      wait_idle();

      // dark only through hysteresis: shortfall negative, exposure floors at zero
      write_register(CSR_MIN_BRIGHTNESS, 16'd0);
      @(negedge clock);
      for (int n = 0; n < 6; n++) queue_frame(plan_model.last_time + 1, 8'd255);
      wait_idle();

      for (int p = 0; p < 12; p++) begin
         pick_settings(p % 4 == 3);
         @(negedge clock);
         plan_scene(150, 1'b0);
         wait_idle();
      end

      // drive into the permanent auto latch, then check it holds
      write_register(CSR_MIN_BRIGHTNESS, 16'd255);
      write_register(CSR_MAX_BRIGHTNESS, 16'd255);
      write_register(CSR_HYSTERESIS, 16'd0);
      write_register(CSR_EXPOSURE_MAX,
                     16'((int'(plan_model.exposure) + 40 > 4095) ? 4095
                                                                 : int'(plan_model.exposure) + 40));
      write_register(CSR_GAIN_MAX,
                     16'((int'(plan_model.gain) + 15 > 255) ? 255 : int'(plan_model.gain) + 15));
      write_register(CSR_UPDATE_INTERVAL, 16'($urandom_range(0, 20)));
      @(negedge clock);
      plan_scene(60, 1'b1);
      wait_idle();

      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
